// File: hw/rtl/iqm_pkg.sv
// Shared types and constants for the I/Q level meter.
// Used by the register block, controller, datapath and top level; no dependencies.
`timescale 1ns / 1ps

package iqm_pkg;

  // APB address width: three 32-bit registers at byte offsets 0, 4, 8
  localparam int AddrW = 4;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_DECAY  = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  localparam logic [15:0] DecayReset  = 16'd65470;
  localparam logic [15:0] PeriodReset = 16'd4096;

  typedef enum logic [1:0] {
    MODE_ABS_I   = 2'd0,
    MODE_ABS_Q   = 2'd1,
    MODE_MAX_ABS = 2'd2,
    MODE_POWER   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] decay;
    logic [15:0] period;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LEVEL,
    ST_WEIGHT,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic level;
    logic weight;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_busy;
  } dp_status_t;

endpackage

// File: hw/rtl/iqm_if.sv
// Valid/ready channel interfaces for the I/Q level meter: sample pairs in, records out.
// No dependencies.
`timescale 1ns / 1ps

interface iqm_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface iqm_record_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_index;
  logic [15:0] sample_total;
  logic [31:0] peak_level;
  logic [47:0] level_sum;
  logic [31:0] average_level;

  modport source (output valid, output start_index, output sample_total,
                  output peak_level, output level_sum, output average_level,
                  input ready);
  modport sink   (input valid, input start_index, input sample_total,
                  input peak_level, input level_sum, input average_level,
                  output ready);
endinterface

// File: hw/rtl/iqm_regs.sv
// APB configuration registers: reduce mode, decay factor, record period.
// Depends on iqm_pkg.
`timescale 1ns / 1ps

module iqm_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [iqm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output iqm_pkg::cfg_t            cfg
);
  import iqm_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_POWER;
      cfg.decay  <= DecayReset;
      cfg.period <= PeriodReset;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MODE:   cfg.mode   <= mode_t'(pwdata[1:0]);
        REG_DECAY:  cfg.decay  <= pwdata[15:0];
        REG_PERIOD: cfg.period <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = {30'd0, cfg.mode};
      REG_DECAY:  prdata = {16'd0, cfg.decay};
      REG_PERIOD: prdata = {16'd0, cfg.period};
      default:    prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/iqm_ctrl.sv
// Sequencer for the level meter: steps each item through square, level, weight, commit.
// Depends on iqm_pkg.
`timescale 1ns / 1ps

module iqm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  iqm_pkg::dp_status_t status,
  output iqm_pkg::dp_cmd_t    cmd
);
  import iqm_pkg::*;

  state_t state;
  state_t state_next;
  logic   go;

  // hold commit while a closing record would overwrite one not yet taken
  assign go = ~(status.emit & status.out_busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      ST_IDLE:   state_next = in_valid ? ST_SQUARE : ST_IDLE;
      ST_SQUARE: state_next = ST_LEVEL;
      ST_LEVEL:  state_next = ST_WEIGHT;
      ST_WEIGHT: state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (!go) begin
          state_next = ST_COMMIT;
        end else begin
          state_next = in_valid ? ST_SQUARE : ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE) | ((state == ST_COMMIT) & go);
    cmd.load   = in_valid & in_ready;
    cmd.square = (state == ST_SQUARE);
    cmd.level  = (state == ST_LEVEL);
    cmd.weight = (state == ST_WEIGHT);
    cmd.commit = (state == ST_COMMIT) & go;
  end

endmodule

// File: hw/rtl/iqm_datapath.sv
// Level meter datapath: abs/square, level select, peak/sum, decayed average, record register.
// Depends on iqm_pkg and iqm_record_if.
`timescale 1ns / 1ps

module iqm_datapath #(
  parameter int SAMPLE_BITS         = 16,
  parameter int DECAY_FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  iqm_pkg::dp_cmd_t              cmd,
  output iqm_pkg::dp_status_t           status,
  input  iqm_pkg::cfg_t                 cfg,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q,
  iqm_record_if.source                  records
);
  import iqm_pkg::*;

  localparam int SqW    = 2 * SAMPLE_BITS + 1;
  localparam int WideW  = (SqW > 32) ? SqW : 33;
  localparam int Dfb    = DECAY_FRACTION_BITS;
  localparam int ProdW  = 32 + Dfb;
  localparam logic [31:0] DecMax = 32'((64'd1 << Dfb) - 64'd1);
  localparam logic [Dfb:0] One   = (Dfb + 1)'(64'd1 << Dfb);

  logic [SAMPLE_BITS-1:0]   raw_i, raw_q;
  logic [SAMPLE_BITS-1:0]   abs_i_next, abs_q_next;
  logic [SAMPLE_BITS-1:0]   abs_i, abs_q;
  logic [2*SAMPLE_BITS-1:0] sq_i, sq_q;
  logic [2*SAMPLE_BITS-1:0] sq_i_next, sq_q_next;
  logic [SqW-1:0]           sq_sum;
  logic [WideW-1:0]         sq_wide;
  logic [31:0]              power_lvl, ext_i, ext_q;
  logic [31:0]              level, level_next;
  logic [Dfb-1:0]           dec_eff;
  logic [Dfb:0]             dec_comp;
  logic [ProdW-1:0]         pa, pb;
  logic [ProdW:0]           avg_sum;
  logic [31:0]              avg_new;
  logic [48:0]              sum_next;
  logic [15:0]              cnt_next;

  logic [15:0] samples_in_record;
  logic [31:0] running_peak;
  logic [47:0] running_sum;
  logic [31:0] running_average;
  logic [31:0] sample_counter;
  logic [31:0] record_start;
  logic        out_valid;

  // square step: absolute values and their squares
  always_comb begin
    abs_i_next = raw_i[SAMPLE_BITS-1] ? (~raw_i + SAMPLE_BITS'(1)) : raw_i;
    abs_q_next = raw_q[SAMPLE_BITS-1] ? (~raw_q + SAMPLE_BITS'(1)) : raw_q;
    sq_i_next  = abs_i_next * abs_i_next;
    sq_q_next  = abs_q_next * abs_q_next;
  end

  // level step: pick by mode, saturate power to 32 bits
  always_comb begin
    sq_sum    = {1'b0, sq_i} + {1'b0, sq_q};
    sq_wide   = WideW'(sq_sum);
    power_lvl = (|sq_wide[WideW-1:32]) ? 32'hFFFF_FFFF : sq_wide[31:0];
    ext_i     = 32'(abs_i);
    ext_q     = 32'(abs_q);
    case (cfg.mode)
      MODE_ABS_I:   level_next = ext_i;
      MODE_ABS_Q:   level_next = ext_q;
      MODE_MAX_ABS: level_next = (ext_i > ext_q) ? ext_i : ext_q;
      MODE_POWER:   level_next = power_lvl;
      default:      level_next = power_lvl;
    endcase
  end

  // weight step: clamp decay below one, form both products
  always_comb begin
    dec_eff  = (32'(cfg.decay) > DecMax) ? DecMax[Dfb-1:0] : Dfb'(cfg.decay);
    dec_comp = One - {1'b0, dec_eff};
    sum_next = {1'b0, running_sum} + 49'(level);
  end

  // commit step
  always_comb begin
    avg_sum  = {1'b0, pa} + {1'b0, pb};
    avg_new  = avg_sum[Dfb+31:Dfb];
    cnt_next = samples_in_record + 16'd1;
  end

  assign status.emit     = (cnt_next >= cfg.period);
  assign status.out_busy = out_valid & ~records.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_i <= sample_i;
      raw_q <= sample_q;
    end
    if (cmd.square) begin
      abs_i <= abs_i_next;
      abs_q <= abs_q_next;
      sq_i  <= sq_i_next;
      sq_q  <= sq_q_next;
    end
    if (cmd.level) begin
      level <= level_next;
    end
    if (cmd.weight) begin
      pa <= ProdW'(running_average) * ProdW'(dec_eff);
      pb <= ProdW'(level) * ProdW'(dec_comp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_in_record <= '0;
      running_peak      <= '0;
      running_sum       <= '0;
      running_average   <= '0;
      sample_counter    <= '0;
      record_start      <= '0;
    end else begin
      if (cmd.weight) begin
        if (level > running_peak) begin
          running_peak <= level;
        end
        running_sum <= sum_next[48] ? 48'hFFFF_FFFF_FFFF : sum_next[47:0];
      end
      if (cmd.commit) begin
        sample_counter <= sample_counter + 32'd1;
        if (status.emit) begin
          samples_in_record <= '0;
          running_peak      <= '0;
          running_sum       <= '0;
          running_average   <= '0;
          record_start      <= sample_counter + 32'd1;
        end else begin
          samples_in_record <= cnt_next;
          running_average   <= avg_new;
        end
      end
    end
  end

  // record output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && status.emit) begin
      out_valid <= 1'b1;
    end else if (records.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && status.emit) begin
      records.start_index   <= record_start;
      records.sample_total  <= cnt_next;
      records.peak_level    <= running_peak;
      records.level_sum     <= running_sum;
      records.average_level <= avg_new;
    end
  end

  assign records.valid = out_valid;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && status.emit |-> !(out_valid && !records.ready))
    else $error("record register overwritten before it was taken");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && status.emit |=> samples_in_record == '0 && running_average == '0 && out_valid)
    else $error("closing a record did not clear the accumulators");

  a_peak_tracks: assert property (@(posedge clk) disable iff (rst)
    cmd.weight |=> running_peak >= $past(level))
    else $error("running peak below the latest level");
`endif

endmodule

// File: hw/rtl/iq_level_meter.sv
// I/Q level meter top level: APB registers, sequencer and datapath.
// Depends on iqm_pkg, iqm_if, iqm_regs, iqm_ctrl and iqm_datapath.
`timescale 1ns / 1ps

// Each accepted I/Q pair is reduced to a level (abs I, abs Q, larger abs, or
// I*I + Q*Q), folded into the running peak, saturating 48-bit sum and an
// exponentially decayed average, and after record_period pairs one record
// goes out and the accumulators restart. An item passes four registered
// steps (square, level select, decay multiply, commit), and a new item is
// accepted only while idle or as the previous item commits; a closing
// item's record is registered as it commits. The commit step holds, and
// input stays stalled, while a closing record finds the previous record
// still untaken. A configuration write is seen by the next step that reads it, even within an item.
module iq_level_meter #(
  parameter int SAMPLE_BITS         = 16,
  parameter int DECAY_FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  iqm_sample_if.sink                samples,
  iqm_record_if.source              records,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [iqm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import iqm_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  iqm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iqm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  iqm_datapath #(
    .SAMPLE_BITS         (SAMPLE_BITS),
    .DECAY_FRACTION_BITS (DECAY_FRACTION_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg),
    .sample_i (samples.sample_i),
    .sample_q (samples.sample_q),
    .records  (records)
  );

endmodule
